// ----- design/binary_to_decimal_ascii_formatter_top_macros.svh -----
// Assertion macros shared by the checker.
`ifndef BINARY_TO_DECIMAL_ASCII_FORMATTER_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_FORMATTER_TOP_MACROS_SVH

// Same-cycle implication.
`define B2DA_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("b2da assertion failed");

// Next-cycle implication.
`define B2DA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("b2da assertion failed");

`endif

// ----- design/b2da_pkg.sv -----
`default_nettype none

package b2da_pkg;

    localparam int VAL_W        = 32;
    localparam int HALF_W       = 16;
    localparam int DIGITS       = 10;
    localparam int BCD_W        = 4 * DIGITS;
    localparam int POS_W        = $clog2(DIGITS);
    localparam int STAGES       = 4;
    localparam int STEPS        = VAL_W / STAGES;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 8;
    localparam int CHAR_W       = 6;

    typedef enum logic [1:0] {
        OP_SUP16 = 2'd0,
        OP_FIX16 = 2'd1,
        OP_FIX32 = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               opcode;
        logic [VAL_W-1:0]  bin;
        logic [BCD_W-1:0]  bcd;
    } dd_word_t;

    // one double-dabble iteration: add 3 to digits >= 5, then shift in a bit
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage

`default_nettype wire

// ----- design/b2da_dd_stage.sv -----
`default_nettype none

module b2da_dd_stage
    import b2da_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dd_word_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output dd_word_t      out_data
);

    logic     valid_reg;
    dd_word_t data_reg;
    dd_word_t data_next;
    logic     load;

    always_comb
    begin
        data_next = in_data;
        for (int k = 0; k < STEPS; k++)
        begin
            data_next.bcd = dd_step(data_next.bcd, data_next.bin[VAL_W-1]);
            data_next.bin = {data_next.bin[VAL_W-2:0], 1'b0};
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- design/b2da_serializer.sv -----
`default_nettype none

module b2da_serializer
    import b2da_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire op_t              in_opcode,
    input  wire logic [BCD_W-1:0] in_bcd,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [CHAR_W-1:0]     out_char,
    output logic                  out_last
);

    logic               have_reg, have_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;
    logic [POS_W-1:0]   start_pos;
    logic               out_free, emit, last_emit, load;
    logic [3:0]         digit;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = have_reg && out_free;
    assign last_emit = emit && (pos_reg == '0);
    assign in_ready  = !have_reg || last_emit;
    assign load      = in_valid && in_ready;
    assign digit     = bcd_reg[4*pos_reg +: 4];

    always_comb
    begin
        unique case (in_opcode)
            OP_FIX32: start_pos = POS_W'(DIGITS - 1);
            OP_FIX16: start_pos = POS_W'(4);
            OP_SUP16:
            begin
                // leading zeros dropped, two digits kept at least
                if (in_bcd[19:16] != 4'd0)
                    start_pos = POS_W'(4);
                else if (in_bcd[15:12] != 4'd0)
                    start_pos = POS_W'(3);
                else if (in_bcd[11:8] != 4'd0)
                    start_pos = POS_W'(2);
                else
                    start_pos = POS_W'(1);
            end
            default:  start_pos = '0;
        endcase
    end

    always_comb
    begin
        have_next = have_reg;
        pos_next  = pos_reg;
        if (load)
        begin
            have_next = 1'b1;
            pos_next  = start_pos;
        end
        else if (last_emit)
        begin
            have_next = 1'b0;
        end
        else if (emit)
        begin
            pos_next = pos_reg - 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            have_reg      <= have_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= in_bcd;
        end
        if (emit)
        begin
            char_reg <= {2'b11, digit};
            last_reg <= (pos_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// ----- design/binary_to_decimal_ascii_formatter_top.sv -----
// Binary to ASCII decimal formatter. Each input word carries a 32-bit value
// (tdata) and a format code (tuser): 0 prints the low 16 bits without leading
// zeros but with at least two digits, 1 prints the low 16 bits as five digits,
// 2 prints all 32 bits as ten digits, 3 is accepted and produces nothing.
// Output words carry one ASCII digit each, most significant first, with tlast
// on the final digit. Conversion runs through a four-stage double-dabble
// pipeline (eight shift-add-3 steps per stage), then a digit serializer with
// a registered output. An input word is taken every cycle while the pipeline
// has room; digits leave one at a time through the single output port, and
// the serializer takes no new number (2 to 5, 5 or 10 digits) before it
// emits the last digit of the current one.
`default_nettype none

module binary_to_decimal_ascii_formatter_top
    import b2da_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]           s_tuser,   // [1:0] opcode
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                      m_tlast    // last_char
);

    logic     st_valid [STAGES+1];
    logic     st_ready [STAGES+1];
    dd_word_t st_data  [STAGES+1];
    dd_word_t in_word;
    op_t      op_in;
    logic [CHAR_W-1:0] out_char;

    assign op_in = op_t'(s_tuser);

    always_comb
    begin
        in_word.opcode = op_in;
        in_word.bcd    = '0;
        if (op_in == OP_FIX32)
            in_word.bin = s_tdata;
        else
            in_word.bin = {{(VAL_W-HALF_W){1'b0}}, s_tdata[HALF_W-1:0]};
    end

    assign st_data[0]  = in_word;
    assign st_valid[0] = s_tvalid && (op_in != OP_NONE);
    assign s_tready    = st_ready[0];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        b2da_dd_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[g]),
            .in_ready  (st_ready[g]),
            .in_data   (st_data[g]),
            .out_valid (st_valid[g+1]),
            .out_ready (st_ready[g+1]),
            .out_data  (st_data[g+1])
        );
    end

    b2da_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[STAGES]),
        .in_ready  (st_ready[STAGES]),
        .in_opcode (st_data[STAGES].opcode),
        .in_bcd    (st_data[STAGES].bcd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W-CHAR_W){1'b0}}, out_char};

endmodule

`default_nettype wire

// ----- design/b2da_checker.sv -----
`default_nettype none
`include "binary_to_decimal_ascii_formatter_top_macros.svh"

module b2da_checker
    import b2da_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic [1:0]           s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast
);

    logic in_seen;
    assign in_seen = s_tvalid && s_tready && (s_tdata != '1 || s_tuser != '1);

    // stalled output word holds
    `B2DA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // every word is an ASCII decimal digit
    `B2DA_ASSERT_NOW(a_digit_legal, m_tvalid,
        m_tdata[7:4] == 4'b0011 && m_tdata[3:0] <= 4'd9)

    // digits of one number leave without gaps
    `B2DA_ASSERT_NEXT(a_digits_packed, m_tvalid && m_tready && !m_tlast, m_tvalid)

    // first cycle after reset shows no output
    `B2DA_ASSERT_NEXT(a_reset_quiet, $rose(rst_n) && !in_seen, !m_tvalid)

endmodule

bind binary_to_decimal_ascii_formatter_top b2da_checker u_checker (.*);

`default_nettype wire
